// File: hw/rtl/irt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package irt_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int MAX_DIGITS  = VALUE_WIDTH;
  localparam int DIG_AW      = $clog2(MAX_DIGITS);
  localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
  localparam int BIT_W       = $clog2(VALUE_WIDTH);
  localparam int BUF_W       = 7;
  localparam int MAX_BUFFER  = 64;
  localparam int RADIX_W     = 5;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  localparam logic [1:0] KIND_BAD_RADIX = 2'd0;
  localparam logic [1:0] KIND_ZERO      = 2'd1;
  localparam logic [1:0] KIND_NUMBER    = 2'd2;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_RADIX  = 2'd1;
  localparam logic [1:0] STATUS_BUFFER = 2'd2;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NONE  = 8'h00;

  typedef struct packed {
    logic [1:0]             kind;
    logic                   neg;
    logic [RADIX_W-1:0]     radix;
    logic [VALUE_WIDTH-1:0] mag;
  } desc_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    case (d)
      4'd0:    c = 8'h30;
      4'd1:    c = 8'h31;
      4'd2:    c = 8'h32;
      4'd3:    c = 8'h33;
      4'd4:    c = 8'h34;
      4'd5:    c = 8'h35;
      4'd6:    c = 8'h36;
      4'd7:    c = 8'h37;
      4'd8:    c = 8'h38;
      4'd9:    c = 8'h39;
      4'd10:   c = 8'h41;
      4'd11:   c = 8'h42;
      4'd12:   c = 8'h43;
      4'd13:   c = 8'h44;
      4'd14:   c = 8'h45;
      default: c = 8'h46;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/irt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module irt_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/irt_front.sv
`timescale 1ns / 1ps
`default_nettype none

module irt_front (
  input  wire logic                          start,
  input  wire logic [63:0]                   value,
  input  wire logic [irt_pkg::RADIX_W-1:0]   radix,
  input  wire logic                          full,
  output logic                               busy,
  output logic                               push,
  output irt_pkg::desc_t                     desc
);

  logic [irt_pkg::VALUE_WIDTH-1:0] v;
  logic                            neg;

  assign v    = value[irt_pkg::VALUE_WIDTH-1:0];
  assign neg  = v[irt_pkg::VALUE_WIDTH-1];
  assign busy = full;
  assign push = start && !full;

  always_comb begin
    desc.neg   = neg;
    desc.radix = radix;
    desc.mag   = neg ? (~v + 1'b1) : v;
    if (radix < irt_pkg::RADIX_MIN || radix > irt_pkg::RADIX_MAX) begin
      desc.kind = irt_pkg::KIND_BAD_RADIX;
    end else if (v == '0) begin
      desc.kind = irt_pkg::KIND_ZERO;
    end else begin
      desc.kind = irt_pkg::KIND_NUMBER;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/irt_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module irt_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire irt_pkg::desc_t push_desc,
  input  wire logic           pop,
  output irt_pkg::desc_t      head,
  output logic                full,
  output logic                empty
);

  irt_pkg::desc_t                ent [irt_pkg::QDEPTH];
  logic [irt_pkg::QPTR_W-1:0]    wp;
  logic [irt_pkg::QPTR_W-1:0]    rp;
  logic [irt_pkg::QCNT_W-1:0]    count;

  assign full  = count == irt_pkg::QCNT_W'(irt_pkg::QDEPTH);
  assign empty = count == '0;
  assign head  = ent[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wp] <= push_desc;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/irt_back.sv
`timescale 1ns / 1ps
`default_nettype none

module irt_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [irt_pkg::BUF_W-1:0]    buffer_size,
  input  wire logic                         empty,
  input  wire irt_pkg::desc_t               head,
  output logic                              pop,
  output logic                              strobe,
  output logic [7:0]                        character,
  output logic [1:0]                        status,
  output logic                              last
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  localparam int W = irt_pkg::VALUE_WIDTH;

  logic [2:0]                    state;
  logic [W-1:0]                  mag;
  logic [irt_pkg::RADIX_W-1:0]   div;
  logic                          neg;
  logic [3:0]                    rem;
  logic [irt_pkg::BIT_W-1:0]     bitc;
  logic [irt_pkg::CNT_W-1:0]     cnt;
  logic [irt_pkg::CNT_W-1:0]     left;
  logic [irt_pkg::DIG_AW-1:0]    ptr;

  logic [4:0]   trial;
  logic         qbit;
  logic [4:0]   diff;
  logic [3:0]   rem_next;
  logic [W-1:0] mag_next;
  logic         digit_done;
  logic [3:0]   rd_digit;
  logic [7:0]   cap;
  logic         too_small;

  assign trial      = {rem, mag[W-1]};
  assign qbit       = trial >= div;
  assign diff       = trial - div;
  assign rem_next   = qbit ? diff[3:0] : trial[3:0];
  assign mag_next   = {mag[W-2:0], qbit};
  assign digit_done = (state == S_DIV) && (bitc == irt_pkg::BIT_W'(W - 1));
  assign pop        = (state == S_IDLE) && !empty;

  assign cap = (buffer_size > irt_pkg::BUF_W'(irt_pkg::MAX_BUFFER))
             ? 8'(irt_pkg::MAX_BUFFER) : 8'(buffer_size);
  assign too_small = (cap < 8'd2) || (8'(cnt) >= cap - 8'd1);

  irt_ram #(
    .WIDTH (4),
    .DEPTH (irt_pkg::MAX_DIGITS)
  ) u_digits (
    .clk   (clk),
    .we    (digit_done),
    .waddr (cnt[irt_pkg::DIG_AW-1:0]),
    .wdata (rem_next),
    .raddr (ptr),
    .rdata (rd_digit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!empty) begin
            unique case (head.kind)
              irt_pkg::KIND_BAD_RADIX: begin
                strobe <= 1'b1;
              end
              irt_pkg::KIND_ZERO: begin
                strobe <= 1'b1;
              end
              default: begin
                state <= S_DIV;
              end
            endcase
          end
        end
        S_DIV: begin
          if (digit_done && mag_next == '0) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (too_small) begin
            strobe <= 1'b1;
            state  <= S_IDLE;
          end else begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          strobe <= neg;
          state  <= S_EMIT;
        end
        S_EMIT: begin
          strobe <= 1'b1;
          if (left == irt_pkg::CNT_W'(1)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        mag  <= head.mag;
        div  <= head.radix;
        neg  <= head.neg;
        rem  <= '0;
        bitc <= '0;
        cnt  <= '0;
        last <= 1'b1;
        if (head.kind == irt_pkg::KIND_BAD_RADIX) begin
          character <= irt_pkg::CHAR_NONE;
          status    <= irt_pkg::STATUS_RADIX;
        end else begin
          character <= irt_pkg::CHAR_ZERO;
          status    <= irt_pkg::STATUS_OK;
        end
      end
      S_DIV: begin
        mag <= mag_next;
        if (digit_done) begin
          rem  <= '0;
          bitc <= '0;
          cnt  <= cnt + 1'b1;
        end else begin
          rem  <= rem_next;
          bitc <= bitc + 1'b1;
        end
      end
      S_CHECK: begin
        character <= irt_pkg::CHAR_NONE;
        status    <= irt_pkg::STATUS_BUFFER;
        last      <= 1'b1;
        ptr       <= irt_pkg::DIG_AW'(cnt - 1'b1);
        left      <= cnt;
      end
      S_LOAD: begin
        character <= irt_pkg::CHAR_MINUS;
        status    <= irt_pkg::STATUS_OK;
        last      <= 1'b0;
        ptr       <= ptr - 1'b1;
      end
      S_EMIT: begin
        character <= irt_pkg::digit_char(rd_digit);
        status    <= irt_pkg::STATUS_OK;
        last      <= left == irt_pkg::CNT_W'(1);
        ptr       <= ptr - 1'b1;
        left      <= left - 1'b1;
      end
      default: begin
        last <= 1'b1;
      end
    endcase
  end

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    strobe && status != irt_pkg::STATUS_OK |-> last)
    else $error("error beat without last");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe)
    else $error("gap inside a character run");

  a_digit_count: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> cnt < irt_pkg::CNT_W'(irt_pkg::MAX_DIGITS))
    else $error("digit store overrun");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> state != S_IDLE || strobe)
    else $error("popped item produced nothing");

endmodule

`default_nettype wire

// File: hw/rtl/integer_to_radix_text_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Converts a signed integer to uppercase ASCII text in radix 2 to 16, one
// character per beat on strobe, most significant first, last on the final
// beat; a bad radix or a too-small buffer gives one error beat instead. The
// receiver cannot stall: a run of characters comes out on consecutive cycles.
// start is taken when busy is low; a two-entry queue holds accepted items
// while the converter works. Each digit comes from a bit-serial divider. The
// longest text is 62 digits; a value with 64 binary digits is rejected as
// too long for the buffer. Zero and bad-radix items give their beat without
// entering the divider.
module integer_to_radix_text_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [63:0]                  value,
  input  wire logic [irt_pkg::RADIX_W-1:0]  radix,
  input  wire logic                         config_write,
  input  wire logic [irt_pkg::BUF_W-1:0]    config_data,
  output logic                              strobe,
  output logic [7:0]                        character,
  output logic [1:0]                        status,
  output logic                              last
);

  logic [irt_pkg::BUF_W-1:0] buffer_size;
  logic                      push;
  logic                      pop;
  logic                      full;
  logic                      empty;
  irt_pkg::desc_t            push_desc;
  irt_pkg::desc_t            head;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= irt_pkg::BUF_W'(irt_pkg::MAX_BUFFER);
    end else if (config_write) begin
      buffer_size <= config_data;
    end
  end

  irt_front u_front (
    .start (start),
    .value (value),
    .radix (radix),
    .full  (full),
    .busy  (busy),
    .push  (push),
    .desc  (push_desc)
  );

  irt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  irt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .buffer_size (buffer_size),
    .empty       (empty),
    .head        (head),
    .pop         (pop),
    .strobe      (strobe),
    .character   (character),
    .status      (status),
    .last        (last)
  );

endmodule

`default_nettype wire
